### rtl/hex_line_walker_macros.svh
// Assertion macros for the hex line walker checker
`ifndef HEX_LINE_WALKER_MACROS_SVH
`define HEX_LINE_WALKER_MACROS_SVH

// clocked assertion, quiet while reset is low
`define HLW_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("hex_line_walker assertion failed");

// implication form on top of the base macro
`define HLW_IMPLY(lbl, ante, cons) `HLW_ASSERT(lbl, (ante) |-> (cons))

`endif

### rtl/hlw_pkg.sv
// ----------------------------------------------------------------------------
// hlw_pkg
// Types and constants shared by the hex line walker modules.
// ----------------------------------------------------------------------------
package hlw_pkg;

	localparam int CUBE_W = 11;   // signed cube coordinate width
	localparam int DIST_W = 11;   // raw hex distance width
	localparam int REM_W  = 7;    // interpolation remainder width

	typedef struct packed {
		logic [7:0] start_col;
		logic [7:0] start_row;
		logic [7:0] end_col;
		logic [7:0] end_row;
	} req_t;

	typedef struct packed {
		logic signed [9:0] hex_col;
		logic [7:0]        hex_row;
		logic [5:0]        step_index;
		logic              last;
		logic              too_far;
	} res_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SETUP,
		ST_WALK
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic single;
		logic step;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic too_far;
		logic zero;
		logic at_end;
	} stat_t;

endpackage

### rtl/hlw_ctrl.sv
// ----------------------------------------------------------------------------
// hlw_ctrl
// Sequencer: load a request, decide single result or walk, then step.
// ----------------------------------------------------------------------------
module hlw_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  hlw_pkg::stat_t stat,
	output hlw_pkg::cmd_t  cmd,
	output logic           busy
);
	import hlw_pkg::*;

	state_t state_q, state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else         state_q <= state_d;
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:  if (start) state_d = ST_SETUP;
			ST_SETUP: begin
				if (stat.too_far || stat.zero) state_d = ST_IDLE;
				else                          state_d = ST_WALK;
			end
			ST_WALK:  if (stat.at_end) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		cmd  = '0;
		busy = 1'b1;
		case (state_q)
			ST_IDLE: begin
				busy     = 1'b0;
				cmd.load = start;
			end
			ST_SETUP: cmd.single = stat.too_far || stat.zero;
			ST_WALK:  cmd.step   = 1'b1;
			default:  busy = 1'b1;
		endcase
	end

endmodule

### rtl/hlw_datapath.sv
// ----------------------------------------------------------------------------
// hlw_datapath
// Cube conversion, distance, incremental interpolation and rounding.
// ----------------------------------------------------------------------------
module hlw_datapath #(
	parameter int MAX_DISTANCE = 63
) (
	input  logic           clk,
	input  logic           arst_n,
	input  hlw_pkg::req_t  req,
	input  hlw_pkg::cmd_t  cmd,
	output hlw_pkg::stat_t stat,
	output logic           strobe,
	output hlw_pkg::res_t  result
);
	import hlw_pkg::*;

	typedef logic signed [CUBE_W-1:0] cube_t;
	typedef logic signed [REM_W:0]    srem_t;

	// cube conversion of the request
	cube_t aq, ar, as_, bq, br, bs, dq, dr, ds;
	cube_t adq, adr, ads;
	logic [DIST_W:0] dsum;
	always_comb begin
		aq  = $signed({3'b0, req.start_col}) - $signed({4'b0, req.start_row[7:1]});
		ar  = $signed({3'b0, req.start_row});
		as_ = -aq - ar;
		bq  = $signed({3'b0, req.end_col}) - $signed({4'b0, req.end_row[7:1]});
		br  = $signed({3'b0, req.end_row});
		bs  = -bq - br;
		dq  = bq - aq;
		dr  = br - ar;
		ds  = bs - as_;
		adq = dq[CUBE_W-1] ? -dq : dq;
		adr = dr[CUBE_W-1] ? -dr : dr;
		ads = ds[CUBE_W-1] ? -ds : ds;
		dsum = {1'b0, adq} + {1'b0, adr} + {1'b0, ads};
	end

	// line registers
	logic [7:0]        col0_q, row0_q;
	logic [DIST_W-1:0] dist_q;
	cube_t             qv_q [3];
	cube_t             dl_q [3];
	logic [REM_W-1:0]  rm_q [3];
	logic [5:0]        idx_q;

	logic [REM_W-1:0] d7;
	assign d7 = dist_q[REM_W-1:0];

	assign stat.too_far = dist_q > DIST_W'(MAX_DISTANCE);
	assign stat.zero    = dist_q == '0;
	assign stat.at_end  = {1'b0, idx_q} == d7;

	// per component rounding and next remainder
	cube_t            rnd [3];
	logic [REM_W-1:0] err [3];
	cube_t            qn  [3];
	logic [REM_W-1:0] rn  [3];
	always_comb begin
		for (int j = 0; j < 3; j++) begin
			logic [REM_W:0] two_r;
			logic           up;
			srem_t          nr;
			two_r = {rm_q[j], 1'b0};
			if (two_r > {1'b0, d7})      up = 1'b1;
			else if (two_r < {1'b0, d7}) up = 1'b0;
			else                          up = !qv_q[j][CUBE_W-1];
			rnd[j] = up ? qv_q[j] + cube_t'(1) : qv_q[j];
			err[j] = up ? d7 - rm_q[j] : rm_q[j];
			nr = $signed({1'b0, rm_q[j]}) + srem_t'(dl_q[j]);
			if (nr >= $signed({1'b0, d7})) begin
				rn[j] = REM_W'(nr - $signed({1'b0, d7}));
				qn[j] = qv_q[j] + cube_t'(1);
			end else if (nr < 0) begin
				rn[j] = REM_W'(nr + $signed({1'b0, d7}));
				qn[j] = qv_q[j] - cube_t'(1);
			end else begin
				rn[j] = REM_W'(nr);
				qn[j] = qv_q[j];
			end
		end
	end

	// rebuild the component with the largest error
	cube_t fq, fr, col_w;
	always_comb begin
		fq = rnd[0];
		fr = rnd[1];
		if (err[0] > err[1] && err[0] > err[2]) fq = -rnd[1] - rnd[2];
		else if (err[1] > err[2])               fr = -rnd[0] - rnd[2];
		col_w = fq + (fr >>> 1);
	end

	// line state
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			col0_q  <= req.start_col;
			row0_q  <= req.start_row;
			dist_q  <= dsum[DIST_W:1];
			qv_q[0] <= aq;
			qv_q[1] <= ar;
			qv_q[2] <= as_;
			dl_q[0] <= dq;
			dl_q[1] <= dr;
			dl_q[2] <= ds;
			for (int j = 0; j < 3; j++) rm_q[j] <= '0;
			idx_q   <= '0;
		end else if (cmd.step) begin
			for (int j = 0; j < 3; j++) begin
				qv_q[j] <= qn[j];
				rm_q[j] <= rn[j];
			end
			idx_q <= idx_q + 6'd1;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) strobe <= 1'b0;
		else         strobe <= cmd.single || cmd.step;
	end

	always_ff @(posedge clk) begin
		if (cmd.single) begin
			result.hex_col    <= $signed({2'b0, col0_q});
			result.hex_row    <= row0_q;
			result.step_index <= '0;
			result.last       <= 1'b1;
			result.too_far    <= stat.too_far;
		end else if (cmd.step) begin
			result.hex_col    <= col_w[9:0];
			result.hex_row    <= fr[7:0];
			result.step_index <= idx_q;
			result.last       <= stat.at_end;
			result.too_far    <= 1'b0;
		end
	end

endmodule

### rtl/hex_line_walker.sv
// ----------------------------------------------------------------------------
// hex_line_walker
// Hex grid line drawing between two odd-row offset hexes.
// ----------------------------------------------------------------------------
// Usage:
//   A request (req) is taken on a clock edge where start is high and busy
//   is low. The block then emits the hexes of the line, one per cycle on
//   result, each marked by a one-cycle strobe; the final hex has last set.
//   A line of distance d gives d+1 results; a zero distance or one beyond
//   MAX_DISTANCE gives one result holding the start hex (too_far set in
//   the latter case).
//   A walked line passes the set-up state, which checks the registered
//   distance, then its first step and the output register; a single
//   result is registered from the set-up state.
//   busy is high through the set-up state and any walk, and no new request
//   is taken while busy is high; busy drops with the final step and a new
//   request may be taken while the final result is still on the outputs.
//   Each component is interpolated by a running quotient and remainder,
//   one add and compare a step, so one hex leaves per cycle.
//   Reset clears the sequencer and the strobe; no result is pending after.
//   The receiver cannot stall: every result is shown for exactly one cycle.
// ----------------------------------------------------------------------------
module hex_line_walker #(
	parameter int MAX_DISTANCE = 63
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  hlw_pkg::req_t req,
	output logic          strobe,
	output hlw_pkg::res_t result
);
	import hlw_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	hlw_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy)
	);

	hlw_datapath #(.MAX_DISTANCE(MAX_DISTANCE)) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.cmd    (cmd),
		.stat   (stat),
		.strobe (strobe),
		.result (result)
	);

endmodule

### rtl/hlw_checker.sv
// ----------------------------------------------------------------------------
// hlw_checker
// Port-level checks on the hex line walker, bound to the top level.
// ----------------------------------------------------------------------------
`include "hex_line_walker_macros.svh"

module hlw_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          start,
	input logic          busy,
	input logic          strobe,
	input hlw_pkg::res_t result
);
	import hlw_pkg::*;

	// an accepted transaction occupies the block next cycle
	`HLW_IMPLY(a_busy_after_accept, start && !busy, ##1 busy)

	// an over-limit result stands alone
	`HLW_IMPLY(a_far_single, strobe && result.too_far, result.last && result.step_index == 6'd0)

	// the line keeps coming one hex per cycle, index counting up
	`HLW_IMPLY(a_walk_steady, strobe && !result.last, ##1 (strobe && result.step_index == $past(result.step_index) + 6'd1))

	// a new line starts at index zero
	`HLW_IMPLY(a_first_zero, strobe && !$past(strobe), result.step_index == 6'd0)

endmodule

bind hex_line_walker hlw_checker u_hlw_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.strobe (strobe),
	.result (result)
);
